// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the shader checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMP(LBL, CLK, RSTN, ANTE, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AST_NXT(LBL, CLK, RSTN, ANTE, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked during reset.
`define AST_ANY(LBL, CLK, ANTE, CONS) \
  LBL: assert property (@(posedge CLK) (ANTE) |=> (CONS)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/aaes_pkg.sv =====
// ----------------------------------------------------------------------------
// aaes_pkg
// Types, constants and per-channel color functions of the ellipse shader.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aaes_pkg;

  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;

  localparam logic [2:0] REG_CENTER  = 3'd0;
  localparam logic [2:0] REG_OUTER   = 3'd1;
  localparam logic [2:0] REG_INNER   = 3'd2;
  localparam logic [2:0] REG_FOCUS   = 3'd3;
  localparam logic [2:0] REG_COLORS  = 3'd4;
  localparam logic [2:0] REG_MODE    = 3'd5;
  localparam logic [2:0] REG_OPTIONS = 3'd6;

  localparam logic [1:0] MODE_STROKE = 2'd0;
  localparam logic [1:0] MODE_FILL   = 2'd1;
  localparam logic [1:0] MODE_BOTH   = 2'd2;

  localparam int DELTA_W    = 35;
  localparam int MAG_W      = 34;
  localparam int HALF_W     = 17;
  localparam int PART_W     = 34;
  localparam int SQ_W       = 68;
  localparam int RAD_W      = 86;
  localparam int ROOT_W     = 46;
  localparam int TRIAL_W    = 92;
  localparam int DIST_LAT   = 4 + ROOT_W;
  localparam int SUM_W      = 39;
  localparam int COV_W      = 9;

  localparam logic [32:0] ONE_PX       = 33'd65536;
  localparam logic [31:0] OPAQUE_WHITE = 32'hffffffff;
  localparam logic [8:0]  COV_FULL     = 9'd256;

  typedef struct packed {
    logic signed [31:0] sample_x;
    logic signed [31:0] sample_y;
    logic [31:0]        paint_pixel;
    logic               span_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic        span_end_out;
  } out_item_t;

  typedef struct packed {
    logic [63:0] center;
    logic [63:0] outer_radii;
    logic [63:0] inner_radii;
    logic [63:0] focus_offsets;
    logic [63:0] colors;
    logic [1:0]  shape_mode;
    logic [1:0]  options;
  } cfg_t;

  function automatic logic [31:0] ch_mul(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] res;
    logic [15:0] p;
    logic [16:0] q;
    res = '0;
    for (int i = 0; i < 4; i++) begin
      p = x[8*i +: 8] * y[8*i +: 8];
      q = 17'(p) + 17'(p[15:8]) + 17'd1;
      res[8*i +: 8] = q[15:8];
    end
    return res;
  endfunction

  function automatic logic [31:0] ch_scale(input logic [8:0] a, input logic [31:0] c);
    logic [31:0] res;
    logic [16:0] p;
    res = '0;
    for (int i = 0; i < 4; i++) begin
      p = c[8*i +: 8] * a;
      res[8*i +: 8] = p[15:8];
    end
    return res;
  endfunction

  function automatic logic [31:0] ch_blend(input logic [8:0] a, input logic [31:0] c0,
                                           input logic [31:0] c1);
    logic [31:0]        res;
    logic signed [8:0]  d;
    logic signed [18:0] p;
    logic signed [18:0] q;
    res = '0;
    for (int i = 0; i < 4; i++) begin
      d = $signed({1'b0, c0[8*i +: 8]}) - $signed({1'b0, c1[8*i +: 8]});
      p = 19'(d) * $signed({10'd0, a});
      q = p >>> 8;
      res[8*i +: 8] = c1[8*i +: 8] + q[7:0];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/aaes_cfg.sv =====
// ----------------------------------------------------------------------------
// aaes_cfg
// Register file of the ellipse shader behind an APB-style port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aaes_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [aaes_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [aaes_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [aaes_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready,
  output aaes_pkg::cfg_t                     cfg
);

  aaes_pkg::cfg_t cfg_r;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[5:3];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        aaes_pkg::REG_CENTER:  cfg_r.center        <= pwdata;
        aaes_pkg::REG_OUTER:   cfg_r.outer_radii   <= pwdata;
        aaes_pkg::REG_INNER:   cfg_r.inner_radii   <= pwdata;
        aaes_pkg::REG_FOCUS:   cfg_r.focus_offsets <= pwdata;
        aaes_pkg::REG_COLORS:  cfg_r.colors        <= pwdata;
        aaes_pkg::REG_MODE:    cfg_r.shape_mode    <= pwdata[1:0];
        aaes_pkg::REG_OPTIONS: cfg_r.options       <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      aaes_pkg::REG_CENTER:  prdata = cfg_r.center;
      aaes_pkg::REG_OUTER:   prdata = cfg_r.outer_radii;
      aaes_pkg::REG_INNER:   prdata = cfg_r.inner_radii;
      aaes_pkg::REG_FOCUS:   prdata = cfg_r.focus_offsets;
      aaes_pkg::REG_COLORS:  prdata = cfg_r.colors;
      aaes_pkg::REG_MODE:    prdata = {62'd0, cfg_r.shape_mode};
      aaes_pkg::REG_OPTIONS: prdata = {62'd0, cfg_r.options};
      default:               prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/aaes_sqrt_stage.sv =====
// ----------------------------------------------------------------------------
// aaes_sqrt_stage
// One registered step of the digit-by-digit square root: decides one root bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aaes_sqrt_stage #(
  parameter int BIT = 0
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [aaes_pkg::RAD_W-1:0]  rem_i,
  input  logic [aaes_pkg::ROOT_W-1:0] root_i,
  output logic [aaes_pkg::RAD_W-1:0]  rem_o,
  output logic [aaes_pkg::ROOT_W-1:0] root_o
);

  localparam int TW = aaes_pkg::TRIAL_W;
  localparam int RW = aaes_pkg::RAD_W;
  localparam int QW = aaes_pkg::ROOT_W;

  logic [TW-1:0] rem_ext;
  logic [TW-1:0] trial;
  logic [TW-1:0] diff;
  logic          fit;
  logic [RW-1:0] rem_r;
  logic [QW-1:0] root_r;

  assign rem_ext = TW'(rem_i);
  assign trial   = (TW'(root_i) << (BIT + 1)) | (TW'(1) << (2 * BIT));
  assign diff    = rem_ext - trial;
  assign fit     = rem_ext >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= fit ? diff[RW-1:0] : rem_i;
      root_r <= fit ? (root_i | (QW'(1) << BIT)) : root_i;
    end
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

// ===== hw/rtl/aaes_dist.sv =====
// ----------------------------------------------------------------------------
// aaes_dist
// Pipelined distance unit: magnitude, split squares, sum, then one square
// root bit per stage, giving the distance with eight extra fraction bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aaes_dist (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [aaes_pkg::DELTA_W-1:0] dx,
  input  logic signed [aaes_pkg::DELTA_W-1:0] dy,
  output logic [aaes_pkg::ROOT_W-1:0]         root_out
);

  localparam int MW = aaes_pkg::MAG_W;
  localparam int HW = aaes_pkg::HALF_W;
  localparam int PW = aaes_pkg::PART_W;
  localparam int SW = aaes_pkg::SQ_W;
  localparam int RW = aaes_pkg::RAD_W;
  localparam int QW = aaes_pkg::ROOT_W;
  localparam int DW = aaes_pkg::DELTA_W;

  logic [DW-1:0] ax;
  logic [DW-1:0] ay;
  logic [MW-1:0] mx_r, my_r;
  logic [PW-1:0] xhh_r, xhl_r, xll_r, yhh_r, yhl_r, yll_r;
  logic [SW-1:0] sqx_r, sqy_r;
  logic [RW-1:0] n_r;
  logic [RW-1:0] rem  [0:QW];
  logic [QW-1:0] root [0:QW];

  assign ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign ay = dy[DW-1] ? DW'(-dy) : DW'(dy);

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r  <= ax[MW-1:0];
      my_r  <= ay[MW-1:0];
      xhh_r <= mx_r[MW-1:HW] * mx_r[MW-1:HW];
      xhl_r <= mx_r[MW-1:HW] * mx_r[HW-1:0];
      xll_r <= mx_r[HW-1:0] * mx_r[HW-1:0];
      yhh_r <= my_r[MW-1:HW] * my_r[MW-1:HW];
      yhl_r <= my_r[MW-1:HW] * my_r[HW-1:0];
      yll_r <= my_r[HW-1:0] * my_r[HW-1:0];
      sqx_r <= (SW'(xhh_r) << (2 * HW)) + (SW'(xhl_r) << (HW + 1)) + SW'(xll_r);
      sqy_r <= (SW'(yhh_r) << (2 * HW)) + (SW'(yhl_r) << (HW + 1)) + SW'(yll_r);
      n_r   <= (RW'(sqx_r) + RW'(sqy_r)) << 16;
    end
  end

  assign rem[0]  = n_r;
  assign root[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_step
    aaes_sqrt_stage #(.BIT(QW - 1 - k)) u_step (
      .clk    (clk),
      .en     (en),
      .rem_i  (rem[k]),
      .root_i (root[k]),
      .rem_o  (rem[k+1]),
      .root_o (root[k+1])
    );
  end

  assign root_out = root[QW];

endmodule

// ===== hw/rtl/antialiased_ellipse_pixel_shader_unit.sv =====
// ----------------------------------------------------------------------------
// antialiased_ellipse_pixel_shader_unit
// Antialiased stroked and filled ellipse shader, one pixel per cycle.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  aaes_pkg::in_item_t
//   out      output     out_valid/out_stall aaes_pkg::out_item_t
//   cfg      input      psel/penable/pready 64-bit registers at 8*index
//
// One pixel is accepted per cycle while a valid output is not stalled.
// Most stages sit in the four distance units, each a 46-step square root.
// A stall on a valid output freezes the whole pipeline; nothing is dropped.
// Reset clears config registers and the valid bits; there is no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module antialiased_ellipse_pixel_shader_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  aaes_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output aaes_pkg::out_item_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [aaes_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [aaes_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [aaes_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int DW  = aaes_pkg::DELTA_W;
  localparam int QW  = aaes_pkg::ROOT_W;
  localparam int UW  = aaes_pkg::SUM_W;
  localparam int LAT = aaes_pkg::DIST_LAT;

  typedef struct packed {
    logic        o_in;
    logic        o_half;
    logic        i_use;
    logic        i_half;
    logic [31:0] o_col;
    logic [31:0] i_col;
    logic        span_end;
  } side_t;

  aaes_pkg::cfg_t cfg;
  logic           en;

  logic [31:0] cx, cy, rx, ry, irx, iry, ofoc, ifoc, scol, fcol;
  logic        o_xmaj, i_xmaj;

  // stage 1
  logic               v1_r;
  logic signed [32:0] d0x_r, d0y_r;
  logic [31:0]        paint1_r;
  logic               span1_r;

  // stage 2
  logic                 v2_r;
  side_t                side2_r;
  logic signed [DW-1:0] odxp_r, odyp_r, odxm_r, odym_r;
  logic signed [DW-1:0] idxp_r, idyp_r, idxm_r, idym_r;
  logic [32:0]          adx, ady;
  logic signed [DW-1:0] ex, ey, ofx, ofy, ifx, ify;
  logic                 has_paint, inner_on, fill_mode;
  logic [31:0]          ocolor, icolor;
  side_t                side2_nxt;

  // delay alongside the distance units
  side_t       side_q [0:LAT-1];
  logic        v_q    [0:LAT-1];
  logic [QW-1:0] d_op, d_om, d_ip, d_im;

  // back end
  logic           v3_r, v4_r, v5_r;
  side_t          side3_r, side4_r, side5_r;
  logic [UW-1:0]  osum_r, isum_r;
  logic [32:0]    oedge, iedge;
  logic [8:0]     oa_nxt, ia_nxt, oa_r, ia_r, ia5_r;
  logic [31:0]    op0s_r;
  logic           out_valid_r;
  aaes_pkg::out_item_t out_data_r;

  aaes_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign cx     = cfg.center[63:32];
  assign cy     = cfg.center[31:0];
  assign rx     = cfg.outer_radii[63:32];
  assign ry     = cfg.outer_radii[31:0];
  assign irx    = cfg.inner_radii[63:32];
  assign iry    = cfg.inner_radii[31:0];
  assign ofoc   = cfg.focus_offsets[63:32];
  assign ifoc   = cfg.focus_offsets[31:0];
  assign scol   = cfg.colors[63:32];
  assign fcol   = cfg.colors[31:0];
  assign o_xmaj = rx > ry;
  assign i_xmaj = irx > iry;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (en) begin
      d0x_r    <= $signed({in_data.sample_x[31], in_data.sample_x}) - $signed({cx[31], cx});
      d0y_r    <= $signed({in_data.sample_y[31], in_data.sample_y}) - $signed({cy[31], cy});
      paint1_r <= in_data.paint_pixel;
      span1_r  <= in_data.span_end;
    end
  end

  always_comb begin
    fill_mode = cfg.shape_mode == aaes_pkg::MODE_FILL;
    has_paint = cfg.options[1] && (cfg.shape_mode != aaes_pkg::MODE_STROKE);
    inner_on  = cfg.options[0] && !fill_mode;
    ocolor    = fill_mode ? fcol : scol;
    icolor    = (cfg.shape_mode == aaes_pkg::MODE_STROKE) ? 32'd0 : fcol;
    adx       = d0x_r[32] ? 33'(-d0x_r) : 33'(d0x_r);
    ady       = d0y_r[32] ? 33'(-d0y_r) : 33'(d0y_r);
    ex        = DW'(d0x_r);
    ey        = DW'(d0y_r);
    ofx       = o_xmaj ? $signed({3'd0, ofoc}) : '0;
    ofy       = o_xmaj ? '0 : $signed({3'd0, ofoc});
    ifx       = i_xmaj ? $signed({3'd0, ifoc}) : '0;
    ify       = i_xmaj ? '0 : $signed({3'd0, ifoc});
    side2_nxt.o_in   = (adx <= {1'b0, rx} + aaes_pkg::ONE_PX) &&
                       (ady <= {1'b0, ry} + aaes_pkg::ONE_PX);
    side2_nxt.o_half = (adx < {2'b0, rx[31:1]}) && (ady < {2'b0, ry[31:1]});
    side2_nxt.i_use  = inner_on && (adx <= {1'b0, irx} + aaes_pkg::ONE_PX) &&
                       (ady <= {1'b0, iry} + aaes_pkg::ONE_PX);
    side2_nxt.i_half = (adx < {2'b0, irx[31:1]}) && (ady < {2'b0, iry[31:1]});
    if (fill_mode && has_paint) begin
      side2_nxt.o_col = (ocolor == aaes_pkg::OPAQUE_WHITE) ? paint1_r :
                        aaes_pkg::ch_mul(paint1_r, ocolor);
    end else begin
      side2_nxt.o_col = ocolor;
    end
    if (has_paint) begin
      side2_nxt.i_col = (icolor == aaes_pkg::OPAQUE_WHITE) ? paint1_r :
                        aaes_pkg::ch_mul(icolor, paint1_r);
    end else begin
      side2_nxt.i_col = icolor;
    end
    side2_nxt.span_end = span1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2_r <= side2_nxt;
      odxp_r  <= ex - ofx;
      odyp_r  <= ey - ofy;
      odxm_r  <= ex + ofx;
      odym_r  <= ey + ofy;
      idxp_r  <= ex - ifx;
      idyp_r  <= ey - ify;
      idxm_r  <= ex + ifx;
      idym_r  <= ey + ify;
    end
  end

  aaes_dist u_dist_op (.clk(clk), .en(en), .dx(odxp_r), .dy(odyp_r), .root_out(d_op));
  aaes_dist u_dist_om (.clk(clk), .en(en), .dx(odxm_r), .dy(odym_r), .root_out(d_om));
  aaes_dist u_dist_ip (.clk(clk), .en(en), .dx(idxp_r), .dy(idyp_r), .root_out(d_ip));
  aaes_dist u_dist_im (.clk(clk), .en(en), .dx(idxm_r), .dy(idym_r), .root_out(d_im));

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= side2_r;
      for (int i = 1; i < LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      for (int i = 0; i < LAT; i++) begin
        v_q[i] <= 1'b0;
      end
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v_q[0] <= v2_r;
      for (int i = 1; i < LAT; i++) begin
        v_q[i] <= v_q[i-1];
      end
      v3_r        <= v_q[LAT-1];
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3_r <= side_q[LAT-1];
      osum_r  <= UW'((({1'b0, d_op} + {1'b0, d_om})) >> 8);
      isum_r  <= UW'((({1'b0, d_ip} + {1'b0, d_im})) >> 8);
    end
  end

  function automatic logic [8:0] cov(input logic half, input logic [UW-1:0] sum,
                                     input logic [32:0] edge_v);
    logic signed [UW:0] diff;
    logic [8:0]         a;
    diff = $signed({1'b0, sum}) - $signed({{(UW-33){1'b0}}, edge_v});
    if (half) begin
      a = aaes_pkg::COV_FULL;
    end else if (diff >= $signed((UW+1)'(aaes_pkg::ONE_PX))) begin
      a = '0;
    end else if (diff > 0) begin
      a = aaes_pkg::COV_FULL - {1'b0, diff[15:8]};
    end else begin
      a = aaes_pkg::COV_FULL;
    end
    return a;
  endfunction

  assign oedge  = o_xmaj ? {rx, 1'b0} : {ry, 1'b0};
  assign iedge  = i_xmaj ? {irx, 1'b0} : {iry, 1'b0};
  assign oa_nxt = cov(side3_r.o_half, osum_r, oedge);
  assign ia_nxt = cov(side3_r.i_half, isum_r, iedge);

  always_ff @(posedge clk) begin
    if (en) begin
      side4_r <= side3_r;
      oa_r    <= oa_nxt;
      ia_r    <= ia_nxt;
      side5_r <= side4_r;
      op0s_r  <= aaes_pkg::ch_scale(oa_r, side4_r.o_col);
      ia5_r   <= ia_r;
      out_data_r.span_end_out <= side5_r.span_end;
      if (!side5_r.o_in) begin
        out_data_r.pixel <= '0;
      end else if (side5_r.i_use) begin
        out_data_r.pixel <= aaes_pkg::ch_blend(ia5_r, side5_r.i_col, op0s_r);
      end else begin
        out_data_r.pixel <= op0s_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/aaes_checker.sv =====
// ----------------------------------------------------------------------------
// aaes_checker
// Port-level checks of the ellipse shader, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aaes_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input aaes_pkg::out_item_t out_data
);

  `AST_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  `AST_IMP(a_stall_from_out, clk, rst_n, in_stall, out_valid && out_stall)
  `AST_ANY(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind antialiased_ellipse_pixel_shader_unit aaes_checker u_aaes_checker (.*);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Ellipse shader testbench
// Drives mapped sample positions into the antialiased ellipse shader through
// several register settings and compares every output pixel with a local
// bit-exact model of the coverage ramp, focal sums and color blending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int  PHASES      = 9;
  localparam int  PHASE_ITEMS = 125;
  localparam int  LIMIT       = 600000;
  localparam longint PX       = 65536;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  aaes_pkg::in_item_t  in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  aaes_pkg::out_item_t out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [aaes_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [aaes_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [aaes_pkg::CFG_DATA_W-1:0] prdata;
  logic        pready;

  antialiased_ellipse_pixel_shader_unit uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  aaes_pkg::cfg_t      shadow;
  aaes_pkg::in_item_t  pending_pixels[$];
  aaes_pkg::out_item_t expected_pixels[$];
  int        cycles = 0;
  int        errors = 0;
  int        pixels_sent = 0;
  int        pixels_checked = 0;

  function automatic logic [63:0] focal_dist(longint dx, longint dy);
    logic [63:0]  ux, uy, r, c;
    logic [127:0] n, c2;
    ux = dx < 0 ? -dx : dx;
    uy = dy < 0 ? -dy : dy;
    n = ({64'd0, ux} * {64'd0, ux} + {64'd0, uy} * {64'd0, uy}) << 16;
    r = '0;
    for (int b = 45; b >= 0; b--) begin
      c = r | (64'd1 << b);
      c2 = {64'd0, c} * {64'd0, c};
      if (c2 <= n) r = c;
    end
    return r;
  endfunction

  function automatic longint ramp_coverage(longint sx, longint sy, longint cx, longint cy,
                                           longint rx, longint ry, longint foc);
    longint adx, ady, fx, fy, edge_sum, sum;
    adx = sx - cx;
    ady = sy - cy;
    if (adx < 0) adx = -adx;
    if (ady < 0) ady = -ady;
    if (adx < (rx >>> 1) && ady < (ry >>> 1)) return 256;
    if (rx > ry) begin
      fx = foc; fy = 0; edge_sum = 2 * rx;
    end else begin
      fx = 0; fy = foc; edge_sum = 2 * ry;
    end
    sum = longint'((focal_dist(sx - (cx + fx), sy - (cy + fy)) +
                    focal_dist(sx - (cx - fx), sy - (cy - fy))) >> 8);
    if (sum >= edge_sum + PX) return 0;
    if (sum > edge_sum) return 256 - ((sum - edge_sum) >>> 8);
    return 256;
  endfunction

  function automatic logic [31:0] chan_product(logic [31:0] x, logic [31:0] y);
    logic [31:0] res;
    for (int i = 0; i < 4; i++) res[8*i +: 8] = 8'((int'(x[8*i +: 8]) * int'(y[8*i +: 8])) / 255);
    return res;
  endfunction

  function automatic logic [31:0] chan_scale(longint a, logic [31:0] c);
    logic [31:0] res;
    for (int i = 0; i < 4; i++) res[8*i +: 8] = 8'((longint'(c[8*i +: 8]) * a) >>> 8);
    return res;
  endfunction

  function automatic logic [31:0] chan_mix(longint a, logic [31:0] c0, logic [31:0] c1);
    logic [31:0] res;
    longint      d;
    for (int i = 0; i < 4; i++) begin
      d = (longint'(c0[8*i +: 8]) - longint'(c1[8*i +: 8])) * a;
      res[8*i +: 8] = 8'(longint'(c1[8*i +: 8]) + (d >>> 8));
    end
    return res;
  endfunction

  function automatic aaes_pkg::out_item_t shade_pixel(aaes_pkg::in_item_t px, aaes_pkg::cfg_t k);
    aaes_pkg::out_item_t res;
    longint      sx, sy, cx, cy, rx, ry, irx, iry, ofoc, ifoc, adx, ady, a;
    logic [31:0] ocolor, icolor, op0, p0;
    logic        inner_on, has_paint, fill_path;
    sx = longint'(px.sample_x);
    sy = longint'(px.sample_y);
    cx = longint'($signed(k.center[63:32]));
    cy = longint'($signed(k.center[31:0]));
    rx = longint'({32'd0, k.outer_radii[63:32]});
    ry = longint'({32'd0, k.outer_radii[31:0]});
    irx = longint'({32'd0, k.inner_radii[63:32]});
    iry = longint'({32'd0, k.inner_radii[31:0]});
    ofoc = longint'({32'd0, k.focus_offsets[63:32]});
    ifoc = longint'({32'd0, k.focus_offsets[31:0]});
    ocolor = k.colors[63:32];
    icolor = k.colors[31:0];
    inner_on = k.options[0];
    has_paint = k.options[1];
    fill_path = 1'b0;
    if (k.shape_mode == aaes_pkg::MODE_STROKE) begin
      icolor = '0; has_paint = 1'b0;
    end
    if (k.shape_mode == aaes_pkg::MODE_FILL) begin
      ocolor = icolor; fill_path = 1'b1; inner_on = 1'b0;
    end
    adx = sx - cx;
    ady = sy - cy;
    if (adx < 0) adx = -adx;
    if (ady < 0) ady = -ady;
    res.pixel = '0;
    res.span_end_out = px.span_end;
    if (adx <= rx + PX && ady <= ry + PX) begin
      op0 = ocolor;
      if (fill_path && has_paint) begin
        op0 = px.paint_pixel;
        if (ocolor != aaes_pkg::OPAQUE_WHITE) op0 = chan_product(op0, ocolor);
      end
      a = ramp_coverage(sx, sy, cx, cy, rx, ry, ofoc);
      if (a < 256) op0 = chan_scale(a, op0);
      p0 = op0;
      if (inner_on && adx <= irx + PX && ady <= iry + PX) begin
        p0 = icolor;
        if (has_paint) begin
          p0 = px.paint_pixel;
          if (icolor != aaes_pkg::OPAQUE_WHITE) p0 = chan_product(icolor, p0);
        end
        a = ramp_coverage(sx, sy, cx, cy, irx, iry, ifoc);
        if (a < 256) p0 = chan_mix(a, p0, op0);
      end
      res.pixel = p0;
    end
    return res;
  endfunction

  function automatic logic idle_now();
    if (cycles >= 3000 && cycles < 7000) return 1'b0;
    return $urandom_range(99) < 29;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_pixels.push_back(shade_pixel(in_data, shadow));
        pixels_sent <= pixels_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_pixels.size() > 0 && !idle_now()) begin
          in_data <= pending_pixels.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    aaes_pkg::out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= idle_now();
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected transaction: pixel %h", out_data.pixel);
          errors <= errors + 1;
        end else begin
          want = expected_pixels.pop_front();
          pixels_checked <= pixels_checked + 1;
          if (out_data.pixel !== want.pixel) begin
            $error("pixel: expected %h, actual %h", want.pixel, out_data.pixel);
            errors <= errors + 1;
          end
          if (out_data.span_end_out !== want.span_end_out) begin
            $error("span_end_out: expected %b, actual %b", want.span_end_out,
                   out_data.span_end_out);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= aaes_pkg::CFG_ADDR_W'({idx, 3'b000}); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      aaes_pkg::REG_CENTER:  shadow.center = value;
      aaes_pkg::REG_OUTER:   shadow.outer_radii = value;
      aaes_pkg::REG_INNER:   shadow.inner_radii = value;
      aaes_pkg::REG_FOCUS:   shadow.focus_offsets = value;
      aaes_pkg::REG_COLORS:  shadow.colors = value;
      aaes_pkg::REG_MODE:    shadow.shape_mode = value[1:0];
      aaes_pkg::REG_OPTIONS: shadow.options = value[1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_pixels.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic setup_phase(int p);
    logic [31:0] rx, ry, irx, iry, cx, cy;
    rx = ($urandom_range(1, 40) << 16) | $urandom_range(0, 65535);
    ry = ($urandom_range(1, 40) << 16) | $urandom_range(0, 65535);
    irx = rx - (rx >> $urandom_range(1, 3));
    iry = ry - (ry >> $urandom_range(1, 3));
    cx = $urandom;
    cy = $urandom;
    if (p == 7) begin
      write_reg(aaes_pkg::REG_CENTER, '1); write_reg(aaes_pkg::REG_OUTER, '1);
      write_reg(aaes_pkg::REG_INNER, '1);
      write_reg(aaes_pkg::REG_FOCUS, '1); write_reg(aaes_pkg::REG_COLORS, '1);
    end else if (p == 6) begin
      write_reg(aaes_pkg::REG_CENTER, '0); write_reg(aaes_pkg::REG_OUTER, '0);
      write_reg(aaes_pkg::REG_INNER, '0);
      write_reg(aaes_pkg::REG_FOCUS, '0);
      write_reg(aaes_pkg::REG_COLORS, {$urandom, $urandom});
    end else begin
      write_reg(aaes_pkg::REG_CENTER, {cx, cy});
      write_reg(aaes_pkg::REG_OUTER, {rx, ry});
      write_reg(aaes_pkg::REG_INNER, {irx, iry});
      write_reg(aaes_pkg::REG_FOCUS, {$urandom_range(0, (rx > ry ? rx : ry)),
                                      $urandom_range(0, (irx > iry ? irx : iry))});
      write_reg(aaes_pkg::REG_COLORS,
                {(p % 3 == 0) ? aaes_pkg::OPAQUE_WHITE : 32'($urandom),
                 (p % 2 == 0) ? aaes_pkg::OPAQUE_WHITE : 32'($urandom)});
    end
    write_reg(aaes_pkg::REG_MODE, 64'(p % 4));
    write_reg(aaes_pkg::REG_OPTIONS, 64'((p + p / 4) % 4));
  endtask

  function automatic aaes_pkg::in_item_t near_pixel(aaes_pkg::cfg_t k);
    aaes_pkg::in_item_t px;
    longint   rx, ry, span_x, span_y;
    rx = longint'({32'd0, k.outer_radii[63:32]});
    ry = longint'({32'd0, k.outer_radii[31:0]});
    span_x = rx + 3 * PX;
    span_y = ry + 3 * PX;
    if (span_x > 64'h3fffffff) span_x = 64'h3fffffff;
    if (span_y > 64'h3fffffff) span_y = 64'h3fffffff;
    px.sample_x = 32'(longint'($signed(k.center[63:32])) +
                      longint'($urandom_range(0, 32'(2 * span_x))) - span_x);
    px.sample_y = 32'(longint'($signed(k.center[31:0])) +
                      longint'($urandom_range(0, 32'(2 * span_y))) - span_y);
    px.paint_pixel = $urandom;
    px.span_end = ($urandom_range(15) == 0);
    if ($urandom_range(9) == 0) begin
      px.sample_x = $urandom;
      px.sample_y = $urandom;
      px.span_end = $urandom_range(1);
    end
    return px;
  endfunction

  function automatic aaes_pkg::in_item_t make_pixel(logic [31:0] x, logic [31:0] y,
                                                    logic [31:0] paint, logic last);
    aaes_pkg::in_item_t px;
    px.sample_x = x; px.sample_y = y; px.paint_pixel = paint; px.span_end = last;
    return px;
  endfunction

  initial begin
    shadow = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(aaes_pkg::REG_CENTER, {32'sd10 << 16, 32'sd10 << 16});
    write_reg(aaes_pkg::REG_OUTER, {32'd7 << 16, 32'd4 << 16});
    write_reg(aaes_pkg::REG_INNER, {32'd5 << 16, 32'd2 << 16});
    write_reg(aaes_pkg::REG_FOCUS, {32'h0005_8000, 32'h0004_8000});
    write_reg(aaes_pkg::REG_COLORS, {32'hff20_40c0, 32'h80ff_0010});
    write_reg(aaes_pkg::REG_MODE, 64'(aaes_pkg::MODE_BOTH));
    write_reg(aaes_pkg::REG_OPTIONS, 64'd3);
    pending_pixels.push_back(make_pixel(32'sd10 << 16, 32'sd10 << 16, 32'hffffffff, 1'b0));
    pending_pixels.push_back(make_pixel(32'sd12 << 16, 32'sd11 << 16, 32'h0, 1'b1));
    pending_pixels.push_back(make_pixel(32'sd17 << 16, 32'sd10 << 16, 32'h12345678, 1'b0));
    pending_pixels.push_back(make_pixel(32'h0011_8000, 32'sd10 << 16, 32'h87654321, 1'b0));
    pending_pixels.push_back(make_pixel(32'sd18 << 16, 32'sd10 << 16, 32'hffffffff, 1'b0));
    pending_pixels.push_back(make_pixel(32'sd19 << 16, 32'sd10 << 16, 32'hffffffff, 1'b1));
    pending_pixels.push_back(make_pixel(32'sd10 << 16, 32'sd14 << 16, 32'haaaaaaaa, 1'b0));
    pending_pixels.push_back(make_pixel(32'sd10 << 16, 32'h000e_c000, 32'h55555555, 1'b0));
    pending_pixels.push_back(make_pixel(32'sd15 << 16, 32'sd12 << 16, 32'h00ff00ff, 1'b0));
    pending_pixels.push_back(make_pixel(32'sd14 << 16, 32'sd13 << 16, 32'hff00ff00, 1'b0));
    pending_pixels.push_back(make_pixel(32'sd3 << 16, 32'sd10 << 16, 32'hffffffff, 1'b0));
    pending_pixels.push_back(make_pixel(32'h7fffffff, 32'h7fffffff, 32'hffffffff, 1'b1));
    pending_pixels.push_back(make_pixel(32'h80000000, 32'h80000000, 32'h0, 1'b0));
    pending_pixels.push_back(make_pixel(32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b1));
    pending_pixels.push_back(make_pixel(32'h0, 32'h0, 32'h0, 1'b0));
    wait_drained();
    write_reg(aaes_pkg::REG_MODE, 64'(aaes_pkg::MODE_FILL));
    for (int i = 0; i < 5; i++) pending_pixels.push_back(near_pixel(shadow));
    wait_drained();
    write_reg(aaes_pkg::REG_MODE, 64'(aaes_pkg::MODE_STROKE));
    for (int i = 0; i < 5; i++) pending_pixels.push_back(near_pixel(shadow));
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      setup_phase(p);
      for (int i = 0; i < PHASE_ITEMS; i++) pending_pixels.push_back(near_pixel(shadow));
      wait_drained();
    end

    $display("Ran %0d pixels through %0d register settings; %0d results compared.",
             pixels_sent, PHASES + 3, pixels_checked);
    $display("Settings covered every draw mode, every option pair and extreme registers.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== antialiased_ellipse_pixel_shader_unit.f =====
+incdir+hw/rtl
hw/rtl/aaes_pkg.sv
hw/rtl/aaes_cfg.sv
hw/rtl/aaes_sqrt_stage.sv
hw/rtl/aaes_dist.sv
hw/rtl/antialiased_ellipse_pixel_shader_unit.sv
hw/rtl/aaes_checker.sv
sim/testbench.sv
